FILE: src/json_string_unescape_assert.svh
// assertion macros for the json string unescape block
// used by the top level only; needs a clock and an active-low reset signal
`ifndef JSON_STRING_UNESCAPE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define JSU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// next-cycle implication, checked outside reset
`define JSU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

FILE: src/jsu_pkg.sv
// shared types and codes for the json string unescape block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package jsu_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERR   = 2'd2;

    // error codes
    localparam logic [3:0] ERR_NO_OPEN    = 4'd0;
    localparam logic [3:0] ERR_CTRL       = 4'd1;
    localparam logic [3:0] ERR_UTF8       = 4'd2;
    localparam logic [3:0] ERR_INC_ESC    = 4'd3;
    localparam logic [3:0] ERR_BAD_ESC    = 4'd4;
    localparam logic [3:0] ERR_SHORT_HEX  = 4'd5;
    localparam logic [3:0] ERR_BAD_HEX    = 4'd6;
    localparam logic [3:0] ERR_MISS_LOW   = 4'd7;
    localparam logic [3:0] ERR_BAD_LOW    = 4'd8;
    localparam logic [3:0] ERR_UNPAIRED   = 4'd9;
    localparam logic [3:0] ERR_UNTERM     = 4'd10;

    // job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // results caused by one source byte
    typedef struct packed {
        logic [2:0]      count;   // 1..4
        logic [1:0]      kind;
        logic [3:0]      code;
        logic [3:0][7:0] data;    // data[0] leaves first
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

FILE: src/jsu_front.sv
// front part: accepts source bytes, runs the string decode state and
// builds one job per byte that has results; depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_byte,
    input  logic          in_eos,
    input  jsu_pkg::q_status_t q_stat,
    output logic          push,
    output jsu_pkg::job_t push_job
);
    import jsu_pkg::*;

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_STR     = 3'd1;
    localparam logic [2:0] M_UTF8    = 3'd2;
    localparam logic [2:0] M_ESC     = 3'd3;
    localparam logic [2:0] M_HEX_HI  = 3'd4;
    localparam logic [2:0] M_WANT_BS = 3'd5;
    localparam logic [2:0] M_WANT_U  = 3'd6;
    localparam logic [2:0] M_HEX_LO  = 3'd7;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [8:0] escape_byte(input logic [7:0] c);
        logic [8:0] r;
        case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5c:   r = {1'b1, 8'h5c};
            8'h2f:   r = {1'b1, 8'h2f};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0c};
            8'h6e:   r = {1'b1, 8'h0a};
            8'h72:   r = {1'b1, 8'h0d};
            8'h74:   r = {1'b1, 8'h09};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] seq_len(input logic [7:0] lead);
        logic [2:0] r;
        if (lead < 8'he0)      r = 3'd2;
        else if (lead < 8'hf0) r = 3'd3;
        else                   r = 3'd4;
        return r;
    endfunction

    function automatic job_t encode_cp(input logic [20:0] cp);
        job_t j;
        j = '0;
        j.kind = KIND_DATA;
        if (cp <= 21'h7f) begin
            j.count   = 3'd1;
            j.data[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            j.count   = 3'd2;
            j.data[0] = {3'b110, cp[10:6]};
            j.data[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            j.count   = 3'd3;
            j.data[0] = {4'b1110, cp[15:12]};
            j.data[1] = {2'b10, cp[11:6]};
            j.data[2] = {2'b10, cp[5:0]};
        end else begin
            j.count   = 3'd4;
            j.data[0] = {5'b11110, cp[20:18]};
            j.data[1] = {2'b10, cp[17:12]};
            j.data[2] = {2'b10, cp[11:6]};
            j.data[3] = {2'b10, cp[5:0]};
        end
        return j;
    endfunction

    logic [2:0]  mode_reg, mode_next;
    logic [15:0] hex_accum_reg, hex_accum_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [9:0]  high_half_reg, high_half_next;
    logic [1:0]  utf8_left_reg, utf8_left_next;
    logic [20:0] utf8_accum_reg, utf8_accum_next;
    logic [7:0]  held_reg [3];

    logic        held_we;
    logic [1:0]  held_wa;
    logic        accept;
    logic [2:0]  total;
    logic [2:0]  idx;
    logic [20:0] acc_new;
    logic [20:0] acc_min;
    logic [4:0]  hexd;
    logic [15:0] hex_full;
    logic [8:0]  esc;
    logic [20:0] cp_pair;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    assign total    = seq_len(held_reg[0]);
    assign idx      = total - {1'b0, utf8_left_reg};
    assign acc_new  = {utf8_accum_reg[14:0], in_byte[5:0]};
    assign acc_min  = (total == 3'd2) ? 21'h80 : ((total == 3'd3) ? 21'h800 : 21'h10000);
    assign hexd     = hex_digit(in_byte);
    assign hex_full = {hex_accum_reg[11:0], hexd[3:0]};
    assign esc      = escape_byte(in_byte);
    assign cp_pair  = 21'h10000 + {1'b0, high_half_reg, hex_full[9:0]};

    always_comb begin
        mode_next       = mode_reg;
        hex_accum_next  = hex_accum_reg;
        hex_count_next  = hex_count_reg;
        high_half_next  = high_half_reg;
        utf8_left_next  = utf8_left_reg;
        utf8_accum_next = utf8_accum_reg;
        held_we         = 1'b0;
        held_wa         = 2'd0;
        push            = 1'b0;
        push_job        = '0;

        if (accept) begin
            // fault is the common outcome, filled in first and overridden below
            push_job.kind  = KIND_ERR;
            push_job.count = 3'd1;
            case (mode_reg)
                M_STR: begin
                    if (in_eos) begin
                        push = 1'b1; push_job.code = ERR_UNTERM; mode_next = M_IDLE;
                    end else if (in_byte == 8'h22) begin
                        push = 1'b1; push_job.kind = KIND_CLOSE; mode_next = M_IDLE;
                    end else if (in_byte < 8'h20) begin
                        push = 1'b1; push_job.code = ERR_CTRL; mode_next = M_IDLE;
                    end else if (in_byte >= 8'h80) begin
                        if (in_byte < 8'hc2 || in_byte > 8'hf4) begin
                            push = 1'b1; push_job.code = ERR_UTF8; mode_next = M_IDLE;
                        end else begin
                            held_we        = 1'b1;
                            held_wa        = 2'd0;
                            utf8_left_next = 2'(seq_len(in_byte) - 3'd1);
                            if (in_byte < 8'he0)
                                utf8_accum_next = {16'd0, in_byte[4:0]};
                            else if (in_byte < 8'hf0)
                                utf8_accum_next = {17'd0, in_byte[3:0]};
                            else
                                utf8_accum_next = {18'd0, in_byte[2:0]};
                            mode_next = M_UTF8;
                        end
                    end else if (in_byte == 8'h5c) begin
                        mode_next = M_ESC;
                    end else begin
                        push = 1'b1; push_job.kind = KIND_DATA; push_job.data[0] = in_byte;
                    end
                end
                M_UTF8: begin
                    if (in_eos || in_byte[7:6] != 2'b10 || utf8_left_reg == 2'd0) begin
                        push = 1'b1; push_job.code = ERR_UTF8; mode_next = M_IDLE;
                    end else begin
                        utf8_accum_next = acc_new;
                        if (utf8_left_reg > 2'd1) begin
                            held_we        = (idx < 3'd3);
                            held_wa        = idx[1:0];
                            utf8_left_next = utf8_left_reg - 2'd1;
                        end else begin
                            utf8_left_next = 2'd0;
                            if (acc_new < acc_min || acc_new > 21'h10ffff ||
                                (acc_new >= 21'hd800 && acc_new <= 21'hdfff)) begin
                                push = 1'b1; push_job.code = ERR_UTF8; mode_next = M_IDLE;
                            end else begin
                                push            = 1'b1;
                                push_job.kind   = KIND_DATA;
                                push_job.count  = total;
                                push_job.data[0] = held_reg[0];
                                case (total)
                                    3'd2: begin
                                        push_job.data[1] = in_byte;
                                    end
                                    3'd3: begin
                                        push_job.data[1] = held_reg[1];
                                        push_job.data[2] = in_byte;
                                    end
                                    default: begin
                                        push_job.data[1] = held_reg[1];
                                        push_job.data[2] = held_reg[2];
                                        push_job.data[3] = in_byte;
                                    end
                                endcase
                                mode_next = M_STR;
                            end
                        end
                    end
                end
                M_ESC: begin
                    if (in_eos) begin
                        push = 1'b1; push_job.code = ERR_INC_ESC; mode_next = M_IDLE;
                    end else if (in_byte == 8'h75) begin
                        hex_accum_next = 16'd0;
                        hex_count_next = 2'd0;
                        mode_next      = M_HEX_HI;
                    end else if (!esc[8]) begin
                        push = 1'b1; push_job.code = ERR_BAD_ESC; mode_next = M_IDLE;
                    end else begin
                        push = 1'b1; push_job.kind = KIND_DATA; push_job.data[0] = esc[7:0];
                        mode_next = M_STR;
                    end
                end
                M_HEX_HI, M_HEX_LO: begin
                    if (in_eos) begin
                        push = 1'b1; push_job.code = ERR_SHORT_HEX; mode_next = M_IDLE;
                    end else if (!hexd[4]) begin
                        push = 1'b1; push_job.code = ERR_BAD_HEX; mode_next = M_IDLE;
                    end else begin
                        hex_accum_next = hex_full;
                        if (hex_count_reg < 2'd3) begin
                            hex_count_next = hex_count_reg + 2'd1;
                        end else begin
                            hex_count_next = 2'd0;
                            if (mode_reg == M_HEX_HI) begin
                                if (hex_full >= 16'hd800 && hex_full <= 16'hdbff) begin
                                    high_half_next = hex_full[9:0];
                                    mode_next      = M_WANT_BS;
                                end else if (hex_full >= 16'hdc00 && hex_full <= 16'hdfff) begin
                                    push = 1'b1; push_job.code = ERR_UNPAIRED;
                                    mode_next = M_IDLE;
                                end else begin
                                    push      = 1'b1;
                                    push_job  = encode_cp({5'd0, hex_full});
                                    mode_next = M_STR;
                                end
                            end else begin
                                if (hex_full < 16'hdc00 || hex_full > 16'hdfff) begin
                                    push = 1'b1; push_job.code = ERR_BAD_LOW;
                                    mode_next = M_IDLE;
                                end else begin
                                    push      = 1'b1;
                                    push_job  = encode_cp(cp_pair);
                                    mode_next = M_STR;
                                end
                            end
                        end
                    end
                end
                M_WANT_BS: begin
                    if (in_eos || in_byte != 8'h5c) begin
                        push = 1'b1; push_job.code = ERR_MISS_LOW; mode_next = M_IDLE;
                    end else begin
                        mode_next = M_WANT_U;
                    end
                end
                M_WANT_U: begin
                    if (in_eos || in_byte != 8'h75) begin
                        push = 1'b1; push_job.code = ERR_MISS_LOW; mode_next = M_IDLE;
                    end else begin
                        hex_accum_next = 16'd0;
                        hex_count_next = 2'd0;
                        mode_next      = M_HEX_LO;
                    end
                end
                default: begin
                    if (!in_eos && in_byte == 8'h22) begin
                        mode_next = M_STR;
                    end else begin
                        push = 1'b1; push_job.code = ERR_NO_OPEN; mode_next = M_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= M_IDLE;
            hex_accum_reg  <= 16'd0;
            hex_count_reg  <= 2'd0;
            high_half_reg  <= 10'd0;
            utf8_left_reg  <= 2'd0;
            utf8_accum_reg <= 21'd0;
        end else begin
            mode_reg       <= mode_next;
            hex_accum_reg  <= hex_accum_next;
            hex_count_reg  <= hex_count_next;
            high_half_reg  <= high_half_next;
            utf8_left_reg  <= utf8_left_next;
            utf8_accum_reg <= utf8_accum_next;
        end
    end

    // held sequence bytes, always written before they are read
    always_ff @(posedge aclk) begin
        if (held_we) begin
            held_reg[held_wa] <= in_byte;
        end
    end

endmodule

FILE: src/jsu_queue.sv
// short job queue between the decode front and the result back part
// depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  jsu_pkg::job_t push_job,
    input  logic          pop,
    output jsu_pkg::job_t head_job,
    output jsu_pkg::q_status_t q_stat
);
    import jsu_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign q_stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_job     = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: src/jsu_back.sv
// back part: walks the head job one result word per cycle into the
// output register while it is free or being taken; depends on jsu_pkg
`timescale 1ns / 1ps

module jsu_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  jsu_pkg::job_t head_job,
    input  jsu_pkg::q_status_t q_stat,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_kind,
    output logic [7:0]    out_byte,
    output logic [3:0]    out_code,
    output logic          out_last
);
    import jsu_pkg::*;

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [1:0] kind_reg;
    logic [7:0] byte_reg;
    logic [3:0] code_reg;
    logic       last_reg;
    logic       load;
    logic       at_last;

    assign load    = !q_stat.empty && (!valid_reg || out_ready);
    assign at_last = ({1'b0, idx_reg} + 3'd1 == head_job.count);
    assign pop     = load && at_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = at_last ? 2'd0 : idx_reg + 2'd1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= head_job.kind;
            byte_reg <= head_job.data[idx_reg];
            code_reg <= head_job.code;
            last_reg <= at_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_code  = code_reg;
    assign out_last  = last_reg;

endmodule

FILE: src/json_string_unescape.sv
// top level of the json string unescape block
// instantiates jsu_front, jsu_queue and jsu_back; uses jsu_pkg and the assert macros
//
// channel   dir   tdata                          tuser           tlast
// s_        in    [7:0] in_byte                  [0] end_of_src  -
// m_        out   [7:0] out_byte, [11:8] code    [1:0] kind      last_of_run
//
// a source byte is taken whenever the 4-entry job queue has room
// results leave one word per cycle while m_tready is high, so a byte that
// yields k results holds the back part until all k have left; plain text runs
// at one byte per cycle when the output does not stall
// a result passes the job queue and then the output register before it is presented
// synchronous reset; no clearing pass
// output stalls back up through the queue to s_tready
`timescale 1ns / 1ps
`include "json_string_unescape_assert.svh"

module json_string_unescape (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] end_of_source
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);
    import jsu_pkg::*;

    logic      fe_push;
    job_t      fe_job;
    job_t      q_head;
    q_status_t q_stat;
    logic      be_pop;
    logic [7:0] out_byte;
    logic [3:0] out_code;

    jsu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .in_eos   (s_tuser),
        .q_stat   (q_stat),
        .push     (fe_push),
        .push_job (fe_job)
    );

    jsu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fe_push),
        .push_job (fe_job),
        .pop      (be_pop),
        .head_job (q_head),
        .q_stat   (q_stat)
    );

    jsu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_job  (q_head),
        .q_stat    (q_stat),
        .pop       (be_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_byte  (out_byte),
        .out_code  (out_code),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'd0, out_code, out_byte};

    `JSU_ASSERT_IMP(a_no_push_full, aclk, aresetn, fe_push, !q_stat.full)
    `JSU_ASSERT_IMP(a_ctrl_alone, aclk, aresetn, m_tvalid && m_tuser != KIND_DATA, m_tlast && m_tdata[7:0] == 8'd0)
    `JSU_ASSERT_IMP(a_code_err_only, aclk, aresetn, m_tvalid && m_tuser != KIND_ERR, m_tdata[11:8] == 4'd0)
    `JSU_ASSERT_NXT(a_back_moves, aclk, aresetn, !q_stat.empty && (!m_tvalid || m_tready), m_tvalid)

endmodule

FILE: tb/jsu_unescape_monitor.sv
// result checker for the json string unescape testbench
// watches both stream channels, decodes each accepted source word itself and
// compares every result word in order; uses jsu_pkg for kinds and error codes
`timescale 1ns / 1ps

module jsu_unescape_monitor (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] end_of_source
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] error_code, [15:12] zero
    input  logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          pending_words
);
    import jsu_pkg::*;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_TEXT, SCAN_UTF8, SCAN_ESC,
        SCAN_HEX_HI, SCAN_WANT_BS, SCAN_WANT_U, SCAN_HEX_LO
    } scan_mode_e;

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] code;
        logic       last;
    } unescaped_word_t;

    unescaped_word_t expected_words[$];
    unescaped_word_t want;
    int              fails;

    scan_mode_e  scan_mode;
    logic [15:0] hex_accum;
    logic [1:0]  hex_count;
    logic [9:0]  high_half;
    logic [7:0]  utf8_held[3];
    logic [1:0]  utf8_left;
    logic [20:0] utf8_accum;

    function automatic void expect_word(logic [1:0] kind, logic [7:0] data, logic [3:0] code);
        unescaped_word_t w;
        w.kind = kind;
        w.data = data;
        w.code = code;
        w.last = 1'b0;
        expected_words.insert(expected_words.size(), w);
    endfunction

    function automatic void expect_error(logic [3:0] code);
        expect_word(KIND_ERR, 8'h00, code);
        scan_mode = SCAN_IDLE;
    endfunction

    function automatic int unsigned utf8_length(logic [7:0] lead);
        return lead < 8'he0 ? 2 : (lead < 8'hf0 ? 3 : 4);
    endfunction

    // bit 4 set marks a valid hex digit
    function automatic logic [4:0] hex_nibble(logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
        if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            return {1'b1, c[3:0] + 4'd9};
        return 5'b0;
    endfunction

    function automatic void expect_code_point(logic [20:0] cp);
        if (cp <= 21'h7f) begin
            expect_word(KIND_DATA, cp[7:0], 4'd0);
        end else if (cp < 21'h800) begin
            expect_word(KIND_DATA, {3'b110, cp[10:6]}, 4'd0);
            expect_word(KIND_DATA, {2'b10, cp[5:0]}, 4'd0);
        end else if (cp < 21'h10000) begin
            expect_word(KIND_DATA, {4'b1110, cp[15:12]}, 4'd0);
            expect_word(KIND_DATA, {2'b10, cp[11:6]}, 4'd0);
            expect_word(KIND_DATA, {2'b10, cp[5:0]}, 4'd0);
        end else begin
            expect_word(KIND_DATA, {5'b11110, cp[20:18]}, 4'd0);
            expect_word(KIND_DATA, {2'b10, cp[17:12]}, 4'd0);
            expect_word(KIND_DATA, {2'b10, cp[11:6]}, 4'd0);
            expect_word(KIND_DATA, {2'b10, cp[5:0]}, 4'd0);
        end
    endfunction

    function automatic void decode_source_byte(logic [7:0] c, logic eos);
        int          first;
        int unsigned total;
        int unsigned idx;
        logic [20:0] floor_cp;
        logic [4:0]  nib;
        logic [7:0]  esc;
        logic        esc_ok;
        first = expected_words.size();
        case (scan_mode)
            SCAN_TEXT: begin
                if (eos) begin
                    expect_error(ERR_UNTERM);
                end else if (c == CH_QUOTE) begin
                    expect_word(KIND_CLOSE, 8'h00, 4'd0);
                    scan_mode = SCAN_IDLE;
                end else if (c < 8'h20) begin
                    expect_error(ERR_CTRL);
                end else if (c >= 8'h80) begin
                    if (c < 8'hc2 || c > 8'hf4) begin
                        expect_error(ERR_UTF8);
                    end else begin
                        utf8_held[0] = c;
                        utf8_left = 2'(utf8_length(c) - 1);
                        utf8_accum = {13'd0, c & (c < 8'he0 ? 8'h1f : (c < 8'hf0 ? 8'h0f : 8'h07))};
                        scan_mode = SCAN_UTF8;
                    end
                end else if (c == CH_BSLASH) begin
                    scan_mode = SCAN_ESC;
                end else begin
                    expect_word(KIND_DATA, c, 4'd0);
                end
            end
            SCAN_UTF8: begin
                total = utf8_length(utf8_held[0]);
                idx = total - utf8_left;
                if (eos || c[7:6] != 2'b10 || utf8_left == 2'd0) begin
                    expect_error(ERR_UTF8);
                end else begin
                    utf8_accum = {utf8_accum[14:0], c[5:0]};
                    if (utf8_left > 2'd1) begin
                        if (idx < 3) utf8_held[idx] = c;
                        utf8_left = utf8_left - 2'd1;
                    end else begin
                        utf8_left = 2'd0;
                        floor_cp = total == 2 ? 21'h80 : (total == 3 ? 21'h800 : 21'h10000);
                        // overlong, beyond the last plane, or a surrogate
                        if (utf8_accum < floor_cp || utf8_accum > 21'h10ffff ||
                            (utf8_accum >= 21'hd800 && utf8_accum <= 21'hdfff)) begin
                            expect_error(ERR_UTF8);
                        end else begin
                            for (int i = 0; i + 1 < total && i < 3; i++)
                                expect_word(KIND_DATA, utf8_held[i], 4'd0);
                            expect_word(KIND_DATA, c, 4'd0);
                            scan_mode = SCAN_TEXT;
                        end
                    end
                end
            end
            SCAN_ESC: begin
                esc_ok = 1'b1;
                esc = c;
                case (c)
                    CH_QUOTE, CH_BSLASH, 8'h2f: esc = c;
                    8'h62: esc = 8'h08;
                    8'h66: esc = 8'h0c;
                    8'h6e: esc = 8'h0a;
                    8'h72: esc = 8'h0d;
                    8'h74: esc = 8'h09;
                    default: esc_ok = 1'b0;
                endcase
                if (eos) begin
                    expect_error(ERR_INC_ESC);
                end else if (c == CH_U) begin
                    hex_accum = 16'd0;
                    hex_count = 2'd0;
                    scan_mode = SCAN_HEX_HI;
                end else if (!esc_ok) begin
                    expect_error(ERR_BAD_ESC);
                end else begin
                    expect_word(KIND_DATA, esc, 4'd0);
                    scan_mode = SCAN_TEXT;
                end
            end
            SCAN_HEX_HI, SCAN_HEX_LO: begin
                nib = hex_nibble(c);
                if (eos) begin
                    expect_error(ERR_SHORT_HEX);
                end else if (!nib[4]) begin
                    expect_error(ERR_BAD_HEX);
                end else begin
                    hex_accum = {hex_accum[11:0], nib[3:0]};
                    if (hex_count < 2'd3) begin
                        hex_count = hex_count + 2'd1;
                    end else begin
                        hex_count = 2'd0;
                        if (scan_mode == SCAN_HEX_HI) begin
                            if (hex_accum >= 16'hd800 && hex_accum <= 16'hdbff) begin
                                high_half = hex_accum[9:0];
                                scan_mode = SCAN_WANT_BS;
                            end else if (hex_accum >= 16'hdc00 && hex_accum <= 16'hdfff) begin
                                expect_error(ERR_UNPAIRED);
                            end else begin
                                expect_code_point({5'd0, hex_accum});
                                scan_mode = SCAN_TEXT;
                            end
                        end else if (hex_accum < 16'hdc00 || hex_accum > 16'hdfff) begin
                            expect_error(ERR_BAD_LOW);
                        end else begin
                            expect_code_point(21'h10000 + {1'b0, high_half, hex_accum[9:0]});
                            scan_mode = SCAN_TEXT;
                        end
                    end
                end
            end
            SCAN_WANT_BS: begin
                if (eos || c != CH_BSLASH) expect_error(ERR_MISS_LOW);
                else scan_mode = SCAN_WANT_U;
            end
            SCAN_WANT_U: begin
                if (eos || c != CH_U) begin
                    expect_error(ERR_MISS_LOW);
                end else begin
                    hex_accum = 16'd0;
                    hex_count = 2'd0;
                    scan_mode = SCAN_HEX_LO;
                end
            end
            default: begin
                scan_mode = SCAN_IDLE;
                if (!eos && c == CH_QUOTE) scan_mode = SCAN_TEXT;
                else expect_error(ERR_NO_OPEN);
            end
        endcase
        if (expected_words.size() > first)
            expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    function automatic void note_mismatch(string what);
        fails++;
        if (fails <= 10)
            $display("%0t mismatch, %s: got kind %0d tdata %04h last %0d", $realtime, what,
                     m_tuser, m_tdata, m_tlast);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            scan_mode = SCAN_IDLE;
            hex_accum = 16'd0;
            hex_count = 2'd0;
            high_half = 10'd0;
            utf8_held[0] = 8'd0;
            utf8_held[1] = 8'd0;
            utf8_held[2] = 8'd0;
            utf8_left = 2'd0;
            utf8_accum = 21'd0;
            expected_words.delete();
            fails = 0;
        end else begin
            if (s_tvalid && s_tready)
                decode_source_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    note_mismatch("no word expected");
                end else begin
                    want = expected_words.pop_front();
                    if (m_tuser !== want.kind || m_tdata !== {4'd0, want.code, want.data} ||
                        m_tlast !== want.last)
                        note_mismatch($sformatf("want kind %0d byte %02h code %0d last %0d",
                                                want.kind, want.data, want.code, want.last));
                end
            end
        end
        mismatch_count <= fails;
        pending_words <= expected_words.size();
    end

endmodule

FILE: tb/json_string_unescape_tb.sv
// top of the json string unescape testbench: clock, reset, source and sink traffic
// builds directed and random json strings, some broken on purpose; needs the rtl
// and jsu_unescape_monitor, which predicts and checks every result word
`timescale 1ns / 1ps

module json_string_unescape_tb;

    localparam int NUM_ITEMS      = 360;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] in_byte
    logic        s_tuser = 1'b0;    // [0] end_of_source
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [7:0] out_byte, [11:8] error_code, [15:12] zero
    logic [1:0]  m_tuser;           // [1:0] kind
    logic        m_tlast;

    int mismatch_count;
    int pending_words;
    int idle_cycles = 0;
    int items_sent = 0;
    bit src_gaps_on = 1'b1;
    bit sink_gaps_on = 1'b1;
    bit sink_hold_req = 1'b0;

    logic [8:0] source_words[$];    // {end_of_source, byte}

    always #5 aclk = ~aclk;

    json_string_unescape u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    jsu_unescape_monitor u_monitor (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_words  (pending_words)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("json_string_unescape_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result sink: random back-pressure, plus one long hold on request
    initial begin
        int n;
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                sink_hold_req = 1'b0;
            end else if (!sink_gaps_on || $urandom_range(0, 99) < 60) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
                repeat (n) @(posedge aclk);
            end
            if ($urandom_range(0, 29) == 0) sink_gaps_on = !sink_gaps_on;
        end
    end

    function automatic void push_word(logic [7:0] b, logic eos);
        source_words.insert(source_words.size(), {eos, b});
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] d);
        if (d < 4'd10) return CH_ZERO + 8'(d);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(d) - 8'd10;
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic [7:0] escape_char(int unsigned sel);
        case (sel)
            0: return CH_QUOTE;
            1: return CH_BSLASH;
            2: return 8'h2f;
            3: return 8'h62;
            4: return 8'h66;
            5: return 8'h6e;
            6: return 8'h72;
            default: return 8'h74;
        endcase
    endfunction

    function automatic logic [7:0] random_plain();
        logic [7:0] r;
        do r = 8'($urandom_range(8'h20, 8'h7f)); while (r == CH_QUOTE || r == CH_BSLASH);
        return r;
    endfunction

    function automatic void add_hex_escape(logic [15:0] v, int digits = 4);
        push_word(CH_BSLASH, 1'b0);
        push_word(CH_U, 1'b0);
        for (int i = 0; i < digits; i++) push_word(hex_char(v[15 - 4 * i -: 4]), 1'b0);
    endfunction

    function automatic logic [15:0] random_high();
        return ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16'hd800 : 16'hdbff)
                                            : 16'hd800 + 16'($urandom_range(0, 1023));
    endfunction

    function automatic logic [15:0] random_low();
        return ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16'hdc00 : 16'hdfff)
                                            : 16'hdc00 + 16'($urandom_range(0, 1023));
    endfunction

    function automatic void add_utf8(logic [20:0] cp);
        if (cp < 21'h800) begin
            push_word({3'b110, cp[10:6]}, 1'b0);
            push_word({2'b10, cp[5:0]}, 1'b0);
        end else if (cp < 21'h10000) begin
            push_word({4'b1110, cp[15:12]}, 1'b0);
            push_word({2'b10, cp[11:6]}, 1'b0);
            push_word({2'b10, cp[5:0]}, 1'b0);
        end else begin
            push_word({5'b11110, cp[20:18]}, 1'b0);
            push_word({2'b10, cp[17:12]}, 1'b0);
            push_word({2'b10, cp[11:6]}, 1'b0);
            push_word({2'b10, cp[5:0]}, 1'b0);
        end
    endfunction

    function automatic void add_segment();
        int          sel;
        int          k;
        logic [15:0] v;
        logic [20:0] cp;
        sel = $urandom_range(0, 99);
        k = $urandom_range(0, 3);
        if (sel < 35) begin
            repeat ($urandom_range(1, 4)) push_word(random_plain(), 1'b0);
        end else if (sel < 50) begin
            push_word(CH_BSLASH, 1'b0);
            push_word(escape_char($urandom_range(0, 7)), 1'b0);
        end else if (sel < 65) begin
            case (k)
                0: v = 16'($urandom_range(0, 16'h7f));
                1: v = 16'($urandom_range(16'h80, 16'h7ff));
                2: v = 16'($urandom_range(16'h800, 16'hffff));
                default: v = ($urandom_range(0, 1) ? 16'hffff : 16'h0000);
            endcase
            if (v >= 16'hd800 && v <= 16'hdfff) v = v ^ 16'h4000;
            add_hex_escape(v);
        end else if (sel < 75) begin
            add_hex_escape(random_high());
            add_hex_escape(random_low());
        end else if (sel < 95) begin
            case (k)
                0: cp = 21'($urandom_range(21'h80, 21'h7ff));
                1: cp = 21'($urandom_range(21'h800, 21'hffff));
                2: cp = 21'($urandom_range(21'h10000, 21'h10ffff));
                default: cp = ($urandom_range(0, 1) ? 21'h10ffff : 21'h80);
            endcase
            if (cp >= 21'hd800 && cp <= 21'hdfff) cp = cp ^ 21'h4000;
            add_utf8(cp);
        end else begin
            push_word(8'($urandom_range(0, 255)), 1'b0);
        end
    endfunction

    // one broken piece; the block is back in idle once it has been consumed
    function automatic void add_fault();
        logic [7:0]  r;
        logic [7:0]  lead;
        logic [15:0] v;
        case ($urandom_range(0, 13))
            0: push_word(8'($urandom_range(0, 31)), 1'b0);
            1: push_word(8'($urandom_range(0, 1) ? $urandom_range(8'h80, 8'hc1)
                                                 : $urandom_range(8'hf5, 8'hff)), 1'b0);
            2: begin
                lead = 8'($urandom_range(8'hc2, 8'hf4));
                push_word(lead, 1'b0);
                if (lead >= 8'he0 && $urandom_range(0, 1))
                    push_word(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
                r = 8'($urandom_range(0, 255));
                if (r[7:6] == 2'b10) r[7] = 1'b0;
                push_word(r, 1'b0);
            end
            3: begin
                // overlong forms
                if ($urandom_range(0, 1)) begin
                    push_word(8'he0, 1'b0);
                    push_word(8'h80 | 8'($urandom_range(0, 31)), 1'b0);
                end else begin
                    push_word(8'hf0, 1'b0);
                    push_word(8'h80 | 8'($urandom_range(0, 15)), 1'b0);
                    push_word(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
                end
                push_word(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
            end
            4: begin
                // encoded surrogate
                push_word(8'hed, 1'b0);
                push_word(8'ha0 | 8'($urandom_range(0, 31)), 1'b0);
                push_word(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
            end
            5: begin
                // above the last plane
                push_word(8'hf4, 1'b0);
                push_word(8'($urandom_range(8'h90, 8'hbf)), 1'b0);
                push_word(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
                push_word(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
            end
            6: begin
                push_word(CH_BSLASH, 1'b0);
                do r = 8'($urandom_range(0, 255));
                while (r == CH_U || r == CH_QUOTE || r == CH_BSLASH || r == 8'h2f ||
                       r == 8'h62 || r == 8'h66 || r == 8'h6e || r == 8'h72 || r == 8'h74);
                push_word(r, 1'b0);
            end
            7: begin
                add_hex_escape(16'($urandom_range(0, 16'hffff)), int'($urandom_range(0, 3)));
                do r = 8'($urandom_range(0, 255)); while (is_hex(r));
                push_word(r, 1'b0);
            end
            8: add_hex_escape(random_low());
            9: begin
                add_hex_escape(random_high());
                if ($urandom_range(0, 1)) begin
                    do r = 8'($urandom_range(0, 255)); while (r == CH_BSLASH);
                end else begin
                    push_word(CH_BSLASH, 1'b0);
                    do r = 8'($urandom_range(0, 255)); while (r == CH_U);
                end
                push_word(r, 1'b0);
            end
            10: begin
                add_hex_escape(random_high());
                v = 16'($urandom_range(0, 16'hffff));
                if (v >= 16'hdc00 && v <= 16'hdfff) v = v ^ 16'h4000;
                add_hex_escape(v);
            end
            default: begin
                // source runs dry at some point of a piece
                case ($urandom_range(0, 5))
                    0: ;
                    1: begin
                        lead = 8'($urandom_range(8'hc2, 8'hf4));
                        push_word(lead, 1'b0);
                        if (lead >= 8'he0 && $urandom_range(0, 1))
                            push_word(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
                    end
                    2: push_word(CH_BSLASH, 1'b0);
                    3: add_hex_escape(16'($urandom_range(0, 16'hffff)),
                                      int'($urandom_range(0, 3)));
                    4: add_hex_escape(random_high());
                    default: begin
                        add_hex_escape(random_high());
                        push_word(CH_BSLASH, 1'b0);
                    end
                endcase
                push_word(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
    endfunction

    function automatic void add_string();
        int nseg;
        int fault_at;
        bit ended;
        push_word(CH_QUOTE, 1'b0);
        nseg = $urandom_range(0, 6);
        fault_at = ($urandom_range(0, 99) < 35) ? int'($urandom_range(0, nseg)) : -1;
        ended = 1'b0;
        for (int i = 0; i <= nseg && !ended; i++) begin
            if (i == fault_at) begin
                add_fault();
                ended = 1'b1;
            end else if (i < nseg) begin
                add_segment();
            end
        end
        if (!ended) push_word(CH_QUOTE, 1'b0);
    endfunction

    function automatic int pick_gap();
        int r;
        if (!src_gaps_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic send_word(logic [8:0] w);
        int gap;
        gap = pick_gap();
        if ($urandom_range(0, 39) == 0) src_gaps_on = !src_gaps_on;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w[7:0];
        s_tuser <= w[8];
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_queued();
        while (source_words.size() > 0) send_word(source_words.pop_front());
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_words != 0);
    endtask

    initial begin
        bit hold_done;
        bit drain_done;
        hold_done = 1'b0;
        drain_done = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: noise and dry source in idle, a control char, then one string
        // with the top ASCII value, a simple escape, the largest 4-byte sequence and
        // \u0000, then a string cut short by the end of source
        push_word(8'hff, 1'b0);
        push_word(8'h00, 1'b1);
        push_word(CH_QUOTE, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(CH_QUOTE, 1'b0);
        push_word(8'h7f, 1'b0);
        push_word(CH_BSLASH, 1'b0);
        push_word(8'h2f, 1'b0);
        add_utf8(21'h10ffff);
        add_hex_escape(16'h0000);
        push_word(CH_QUOTE, 1'b0);
        push_word(CH_QUOTE, 1'b0);
        push_word(8'hff, 1'b1);
        send_queued();
        wait_drained();

        while (items_sent < NUM_ITEMS) begin
            if (!hold_done && items_sent >= 140) begin
                sink_hold_req = 1'b1;
                hold_done = 1'b1;
            end
            if (!drain_done && items_sent >= 250) begin
                wait_drained();
                drain_done = 1'b1;
            end
            if ($urandom_range(0, 99) < 10) begin
                if ($urandom_range(0, 2) == 0) push_word(8'($urandom_range(0, 255)), 1'b1);
                else push_word(CH_QUOTE ^ 8'($urandom_range(1, 255)), 1'b0);
            end
            add_string();
            send_queued();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("json_string_unescape_tb: PASS");
        else
            $display("json_string_unescape_tb: FAIL");
        $finish;
    end

endmodule
